>>> src/chdec_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants, types and the hex digit decode used by the decoder blocks.
// ----------------------------------------------------------------------------
package chdec_pkg;

   localparam int LINE_BUFFER_DEFAULT = 16;
   localparam int SIZE_BITS_DEFAULT   = 31;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // Progress of the size-line number scan.
   typedef enum logic [2:0] {
      NS_BLANK  = 3'd0,
      NS_SIGN   = 3'd1,
      NS_ZERO   = 3'd2,
      NS_PREFIX = 3'd3,
      NS_DIGITS = 3'd4,
      NS_DONE   = 3'd5
   } num_stage_type;

   typedef struct packed {
      num_stage_type stage;
      logic          negative;
   } scan_state_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> src/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder core
// Strips chunk-size lines and chunk trailers from a raw body byte stream and
// passes out the payload bytes, then one end-of-body word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata               | tuser
//  req     | in  | [7:0] in_byte       | -
//  rsp     | out | [7:0] data_byte     | [0] body_end
//
// One word can enter per cycle. A taken word waits in the input register until it
// is decoded, and its result word is then registered in the output register.
// Size-line and trailer words give no result, but the line feed ending the last
// size line gives the end-of-body word. A full input register keeps its word and
// req_tready stays low while the output register holds a word that rsp_tready
// has not taken. Reset clears the decoder state back to reading a size line.
module http_chunked_body_decoder_core
   import chdec_pkg::*;
#(
   parameter int LINE_BUFFER = LINE_BUFFER_DEFAULT,
   parameter int SIZE_BITS   = SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [0:0] rsp_tuser    // [0] body_end
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff;
   logic       out_end_ff;

   logic       advance;
   logic       result_valid;
   logic [7:0] result_data;
   logic       result_end;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   chdec_fsm #(
      .LINE_BUFFER (LINE_BUFFER),
      .SIZE_BITS   (SIZE_BITS)
   ) u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .char_in      (in_byte_ff),
      .result_valid (result_valid),
      .result_data  (result_data),
      .result_end   (result_end)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance) begin
         out_valid_in = result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result_valid) begin
         out_data_ff <= result_data;
         out_end_ff  <= result_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_end_ff;

endmodule

>>> src/chdec_size_parse.sv
// ----------------------------------------------------------------------------
// Chunk size scanner step
// Next scan state and running hex value for one kept size-line character.
// ----------------------------------------------------------------------------
module chdec_size_parse
   import chdec_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  scan_state_type       scan_cur,
   input  logic [SIZE_BITS-1:0] value_cur,
   input  logic [7:0]           char_in,
   output scan_state_type       scan_nxt,
   output logic [SIZE_BITS-1:0] value_nxt
);

   localparam logic [SIZE_BITS+3:0] VALUE_MAX = {4'd0, {SIZE_BITS{1'b1}}};

   hex_type              hex;
   logic [SIZE_BITS+3:0] shifted;
   logic [SIZE_BITS-1:0] value_add;
   logic                 is_blank;
   logic                 is_sign;
   logic                 is_x;

   always_comb begin
      hex      = hex_digit(char_in);
      shifted  = {value_cur, 4'd0} + {{SIZE_BITS{1'b0}}, hex.val};
      // Saturate at the largest size value instead of wrapping.
      value_add = (shifted > VALUE_MAX) ? {SIZE_BITS{1'b1}} : shifted[SIZE_BITS-1:0];
      is_blank = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB) ||
                 (char_in == CHAR_VT) || (char_in == CHAR_FF);
      is_sign  = (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);
      is_x     = (char_in == CHAR_LOW_X) || (char_in == CHAR_UP_X);

      scan_nxt  = scan_cur;
      value_nxt = value_cur;
      case (scan_cur.stage)
         NS_BLANK, NS_SIGN: begin
            if (scan_cur.stage == NS_BLANK && is_blank) begin
               scan_nxt = scan_cur;
            end else if (scan_cur.stage == NS_BLANK && is_sign) begin
               scan_nxt.negative = (char_in == CHAR_MINUS);
               scan_nxt.stage    = NS_SIGN;
            end else if (char_in == CHAR_ZERO) begin
               scan_nxt.stage = NS_ZERO;
            end else if (hex.ok) begin
               value_nxt      = value_add;
               scan_nxt.stage = NS_DIGITS;
            end else begin
               scan_nxt.stage = NS_DONE;
            end
         end
         NS_ZERO: begin
            if (is_x) begin
               scan_nxt.stage = NS_PREFIX;
            end else if (hex.ok) begin
               value_nxt      = value_add;
               scan_nxt.stage = NS_DIGITS;
            end else begin
               scan_nxt.stage = NS_DONE;
            end
         end
         NS_PREFIX, NS_DIGITS: begin
            if (hex.ok) begin
               value_nxt      = value_add;
               scan_nxt.stage = NS_DIGITS;
            end else begin
               scan_nxt.stage = NS_DONE;
            end
         end
         default: begin
            scan_nxt = scan_cur;
         end
      endcase
   end

endmodule

>>> src/chdec_fsm.sv
// ----------------------------------------------------------------------------
// Chunked body decode state machine
// Holds the decoding phase, size-line scan state and chunk byte count, and
// decides for each word whether it yields a payload or end-of-body result.
// ----------------------------------------------------------------------------
module chdec_fsm
   import chdec_pkg::*;
#(
   parameter int LINE_BUFFER = LINE_BUFFER_DEFAULT,
   parameter int SIZE_BITS   = SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_in,
   output logic       result_valid,
   output logic [7:0] result_data,
   output logic       result_end
);

   localparam int LC_W = (LINE_BUFFER > 2) ? $clog2(LINE_BUFFER) : 1;
   localparam logic [LC_W-1:0] LC_LIMIT = LC_W'(LINE_BUFFER - 1);

   typedef enum logic [2:0] {
      PH_LINE     = 3'd0,
      PH_DATA     = 3'd1,
      PH_TRAIL    = 3'd2,
      PH_TRAIL_LF = 3'd3,
      PH_ENDED    = 3'd4
   } phase_type;

   phase_type            phase_ff,      phase_in;
   logic [LC_W-1:0]      line_chars_ff, line_chars_in;
   scan_state_type       scan_ff,       scan_in;
   logic [SIZE_BITS-1:0] size_ff,       size_in;
   logic [SIZE_BITS-1:0] left_ff,       left_in;

   scan_state_type       scan_step;
   logic [SIZE_BITS-1:0] size_step;

   chdec_size_parse #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parse (
      .scan_cur  (scan_ff),
      .value_cur (size_ff),
      .char_in   (char_in),
      .scan_nxt  (scan_step),
      .value_nxt (size_step)
   );

   always_comb begin
      phase_in      = phase_ff;
      line_chars_in = line_chars_ff;
      scan_in       = scan_ff;
      size_in       = size_ff;
      left_in       = left_ff;
      result_valid  = 1'b0;
      result_data   = 8'd0;
      result_end    = 1'b0;
      case (phase_ff)
         PH_LINE: begin
            if (char_in == CHAR_LF) begin
               if (scan_ff.negative || size_ff == '0) begin
                  phase_in     = PH_ENDED;
                  result_valid = 1'b1;
                  result_end   = 1'b1;
               end else begin
                  left_in  = size_ff;
                  phase_in = PH_DATA;
               end
               line_chars_in = '0;
               scan_in       = '{stage: NS_BLANK, negative: 1'b0};
               size_in       = '0;
            end else if (char_in != CHAR_CR && line_chars_ff < LC_LIMIT) begin
               line_chars_in = line_chars_ff + LC_W'(1);
               scan_in       = scan_step;
               size_in       = size_step;
            end
         end
         PH_DATA: begin
            result_valid = 1'b1;
            result_data  = char_in;
            if (left_ff != '0) begin
               left_in = left_ff - SIZE_BITS'(1);
            end
            if (left_in == '0) begin
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            phase_in = (char_in == CHAR_CR) ? PH_TRAIL_LF : PH_LINE;
         end
         PH_TRAIL_LF: begin
            phase_in = PH_LINE;
         end
         default: begin
            phase_in = PH_ENDED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE;
         line_chars_ff <= '0;
         scan_ff       <= '{stage: NS_BLANK, negative: 1'b0};
         size_ff       <= '0;
         left_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         line_chars_ff <= line_chars_in;
         scan_ff       <= scan_in;
         size_ff       <= size_in;
         left_ff       <= left_in;
      end
   end

endmodule
